// ===== hw/rtl/rse_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, opcodes and types of the instruction executor.
// No dependencies.
package rse_pkg;

    localparam int XLEN        = 32;
    localparam int REG_COUNT   = 32;
    localparam int REG_AW      = $clog2(REG_COUNT);
    // power of two: word index is the low address bits
    localparam int DATA_WORDS  = 128;
    localparam int DMEM_AW     = $clog2(DATA_WORDS);
    localparam int MEM_INDEX_W = 7;

    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_J     = 6'b000010;
    localparam logic [5:0] OP_JAL   = 6'b000011;
    localparam logic [5:0] OP_BEQ   = 6'b000100;
    localparam logic [5:0] OP_BNE   = 6'b000101;
    localparam logic [5:0] OP_ADDI  = 6'b001000;
    localparam logic [5:0] OP_LW    = 6'b100011;
    localparam logic [5:0] OP_SW    = 6'b101011;

    localparam logic [5:0] FN_SLL = 6'd0;
    localparam logic [5:0] FN_JR  = 6'd8;
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;
    localparam logic [5:0] FN_SLT = 6'd42;

    localparam logic [REG_AW-1:0] LINK_REG = REG_AW'(31);

    typedef struct packed {
        logic [XLEN-1:0]        next_pc;
        logic                   branch_taken;
        logic                   reg_write;
        logic [REG_AW-1:0]      write_reg;
        logic [XLEN-1:0]        write_value;
        logic                   mem_write;
        logic [MEM_INDEX_W-1:0] mem_index;
        logic                   unknown_op;
    } rse_result_t;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } rf_wr_t;

    typedef struct packed {
        logic               wr_en;
        logic [DMEM_AW-1:0] index;
        logic [XLEN-1:0]    wdata;
    } dmem_req_t;

    typedef struct packed {
        rse_result_t res;
        logic        is_load;
        rf_wr_t      rf_wr;
        dmem_req_t   dmem;
    } exec_t;

    // reset contents of register i: 10 * i
    function automatic logic [XLEN-1:0] reg_reset_value(input logic [REG_AW-1:0] idx);
        logic [XLEN-1:0] x;
        x = XLEN'(idx);
        return (x << 3) + (x << 1);
    endfunction

    function automatic logic [MEM_INDEX_W-1:0] to_mem_index(input logic [DMEM_AW-1:0] idx);
        return MEM_INDEX_W'(idx);
    endfunction

endpackage

// ===== hw/rtl/rse_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: instruction request and result response.
// Depends on rse_pkg.
interface rse_req_if import rse_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [XLEN-1:0] instr;

    modport source (output valid, output instr, input ready);
    modport sink   (input valid, input instr, output ready);
endinterface

interface rse_rsp_if import rse_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [XLEN-1:0]        next_pc;
    logic                   branch_taken;
    logic                   reg_write;
    logic [REG_AW-1:0]      write_reg;
    logic [XLEN-1:0]        write_value;
    logic                   mem_write;
    logic [MEM_INDEX_W-1:0] mem_index;
    logic                   unknown_op;

    modport source (output valid, output next_pc, output branch_taken, output reg_write,
                    output write_reg, output write_value, output mem_write,
                    output mem_index, output unknown_op, input ready);
    modport sink   (input valid, input next_pc, input branch_taken, input reg_write,
                    input write_reg, input write_value, input mem_write,
                    input mem_index, input unknown_op, output ready);
endinterface

// ===== hw/rtl/rse_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/rse_regfile.sv =====
`timescale 1ns / 1ps
// Register file: two RAM copies for two read ports, valid bits supply reset values.
// Depends on rse_pkg and rse_ram.
module rse_regfile import rse_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [REG_AW-1:0] rd_addr_a,
    input  logic [REG_AW-1:0] rd_addr_b,
    output logic [XLEN-1:0]   rd_data_a,
    output logic [XLEN-1:0]   rd_data_b,
    input  rf_wr_t            wr
);

    logic [REG_COUNT-1:0] valid_reg;
    logic [REG_COUNT-1:0] valid_next;
    logic [REG_AW-1:0]    addr_a_reg;
    logic [REG_AW-1:0]    addr_b_reg;
    logic                 va_reg;
    logic                 vb_reg;
    logic [XLEN-1:0]      ram_a;
    logic [XLEN-1:0]      ram_b;

    rse_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram_a (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr_a),
        .rdata (ram_a)
    );

    rse_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram_b (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr_b),
        .rdata (ram_b)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            va_reg    <= valid_reg[rd_addr_a];
            vb_reg    <= valid_reg[rd_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        addr_a_reg <= rd_addr_a;
        addr_b_reg <= rd_addr_b;
    end

    assign rd_data_a = va_reg ? ram_a : reg_reset_value(addr_a_reg);
    assign rd_data_b = vb_reg ? ram_b : reg_reset_value(addr_b_reg);

endmodule

// ===== hw/rtl/rse_dmem.sv =====
`timescale 1ns / 1ps
// Data memory: one RAM plus per-word valid bits; unwritten words read zero.
// Depends on rse_pkg and rse_ram.
module rse_dmem import rse_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  dmem_req_t       req,
    output logic [XLEN-1:0] rd_data
);

    logic [DATA_WORDS-1:0] valid_reg;
    logic [DATA_WORDS-1:0] valid_next;
    logic                  rd_valid_reg;
    logic [XLEN-1:0]       ram_q;

    rse_ram #(.WIDTH(XLEN), .DEPTH(DATA_WORDS)) u_ram (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (req.index),
        .wdata (req.wdata),
        .raddr (req.index),
        .rdata (ram_q)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (req.wr_en)
        begin
            valid_next[req.index] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[req.index];
        end
    end

    assign rd_data = rd_valid_reg ? ram_q : '0;

endmodule

// ===== hw/rtl/rse_exec.sv =====
`timescale 1ns / 1ps
// Decode and execute: ALU, branch/jump target, load/store index, writeback control.
// Depends on rse_pkg.
module rse_exec import rse_pkg::*; (
    input  logic [XLEN-1:0] instr,
    input  logic [XLEN-1:0] pc,
    input  logic [XLEN-1:0] a,
    input  logic [XLEN-1:0] b,
    output exec_t           ex
);

    logic [5:0]         op;
    logic [5:0]         fn;
    logic [REG_AW-1:0]  rt;
    logic [REG_AW-1:0]  rd;
    logic [4:0]         sh;
    logic [XLEN-1:0]    simm;
    logic [XLEN-1:0]    pc1;
    logic [XLEN-1:0]    jtarget;
    logic [XLEN-1:0]    addr;
    logic [DMEM_AW-1:0] widx;
    logic [XLEN-1:0]    next;
    logic               taken;
    logic               wr;
    logic               mw;
    logic               unk;
    logic               ld;
    logic               mem_op;
    logic [REG_AW-1:0]  wreg;
    logic [XLEN-1:0]    wval;

    assign op      = instr[31:26];
    assign rt      = instr[20:16];
    assign rd      = instr[15:11];
    assign sh      = instr[10:6];
    assign fn      = instr[5:0];
    assign simm    = {{(XLEN-16){instr[15]}}, instr[15:0]};
    assign pc1     = pc + XLEN'(1);
    assign jtarget = {pc1[31:26], instr[25:0]};
    assign addr    = a + simm;
    assign widx    = addr[DMEM_AW+1:2];

    always_comb
    begin
        next   = pc1;
        taken  = 1'b0;
        wr     = 1'b0;
        mw     = 1'b0;
        unk    = 1'b0;
        ld     = 1'b0;
        mem_op = 1'b0;
        wreg   = '0;
        wval   = '0;
        case (op)
            OP_RTYPE:
            begin
                wreg = rd;
                wr   = 1'b1;
                case (fn)
                    FN_ADD: wval = a + b;
                    FN_SUB: wval = a - b;
                    FN_AND: wval = a & b;
                    FN_OR:  wval = a | b;
                    FN_SLT: wval = XLEN'($signed(a) < $signed(b));
                    FN_SLL: wval = b << sh;
                    FN_JR:
                    begin
                        wr    = 1'b0;
                        next  = a;
                        taken = 1'b1;
                    end
                    default:
                    begin
                        wr  = 1'b0;
                        unk = 1'b1;
                    end
                endcase
            end
            OP_ADDI:
            begin
                wr   = 1'b1;
                wreg = rt;
                wval = addr;
            end
            OP_LW:
            begin
                wr     = 1'b1;
                wreg   = rt;
                ld     = 1'b1;
                mem_op = 1'b1;
            end
            OP_SW:
            begin
                mw     = 1'b1;
                mem_op = 1'b1;
            end
            OP_BEQ:
            begin
                if (a == b)
                begin
                    next  = pc1 + simm;
                    taken = 1'b1;
                end
            end
            OP_BNE:
            begin
                if (a != b)
                begin
                    next  = pc1 + simm;
                    taken = 1'b1;
                end
            end
            OP_J:
            begin
                next  = jtarget;
                taken = 1'b1;
            end
            OP_JAL:
            begin
                next  = jtarget;
                taken = 1'b1;
                wr    = 1'b1;
                wreg  = LINK_REG;
                wval  = pc1;
            end
            default:
            begin
                unk = 1'b1;
            end
        endcase

        // r0 is hardwired to zero
        if (wr && wreg == '0)
        begin
            wr = 1'b0;
        end
        if (!wr)
        begin
            wreg = '0;
            wval = '0;
        end

        ex.res.next_pc      = next;
        ex.res.branch_taken = taken;
        ex.res.reg_write    = wr;
        ex.res.write_reg    = wreg;
        ex.res.write_value  = wval;
        ex.res.mem_write    = mw;
        ex.res.mem_index    = mem_op ? to_mem_index(widx) : '0;
        ex.res.unknown_op   = unk;
        ex.is_load          = ld;
        ex.rf_wr.en         = wr && !ld;
        ex.rf_wr.addr       = wreg;
        ex.rf_wr.data       = wval;
        ex.dmem.wr_en       = mw;
        ex.dmem.index       = widx;
        ex.dmem.wdata       = b;
    end

endmodule

// ===== hw/rtl/risc_subset_instruction_executor_core.sv =====
`timescale 1ns / 1ps
// Instruction executor top: register read, execute, data memory, result queue.
// Depends on rse_pkg, rse_if, rse_regfile, rse_dmem, rse_exec.
// Register file read, then execute; lw then adds a data memory read (each a
// synchronous RAM access). A new instruction is taken only when execute and the
// memory stage are empty and the result queue has room.
// Reset: pc 0; valid bits cleared so register i reads 10*i and data memory reads 0.
module risc_subset_instruction_executor_core import rse_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    rse_req_if.sink   req,
    rse_rsp_if.source rsp
);

    logic            acc;
    logic            pop;
    logic            push;
    logic [XLEN-1:0] pc_reg;
    logic            e_valid_reg;
    logic            m_valid_reg;
    logic [XLEN-1:0] instr_reg;
    rse_result_t     m_res_reg;
    rse_result_t     load_res;
    rse_result_t     push_res;
    rse_result_t     fifo_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic [XLEN-1:0] rf_a;
    logic [XLEN-1:0] rf_b;
    logic [XLEN-1:0] dmem_rdata;
    exec_t           ex;
    rf_wr_t          rf_wr;
    dmem_req_t       dmem_req;
    rse_result_t     head;

    assign req.ready = !e_valid_reg && !m_valid_reg && (cnt_reg != 2'd2);
    assign acc       = req.valid && req.ready;

    rse_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr_a (req.instr[25:21]),
        .rd_addr_b (req.instr[20:16]),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b),
        .wr        (rf_wr)
    );

    rse_exec u_exec (
        .instr (instr_reg),
        .pc    (pc_reg),
        .a     (rf_a),
        .b     (rf_b),
        .ex    (ex)
    );

    always_comb
    begin
        dmem_req       = ex.dmem;
        dmem_req.wr_en = e_valid_reg && ex.dmem.wr_en;
    end

    rse_dmem u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (dmem_req),
        .rd_data (dmem_rdata)
    );

    always_comb
    begin
        load_res             = m_res_reg;
        load_res.write_value = m_res_reg.reg_write ? dmem_rdata : '0;
        if (m_valid_reg)
        begin
            rf_wr.en   = m_res_reg.reg_write;
            rf_wr.addr = m_res_reg.write_reg;
            rf_wr.data = dmem_rdata;
        end
        else
        begin
            rf_wr    = ex.rf_wr;
            rf_wr.en = e_valid_reg && ex.rf_wr.en;
        end
    end

    assign push     = (e_valid_reg && !ex.is_load) || m_valid_reg;
    assign push_res = m_valid_reg ? load_res : ex.res;
    assign pop      = rsp.valid && rsp.ready;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            e_valid_reg <= acc;
            m_valid_reg <= e_valid_reg && ex.is_load;
            if (e_valid_reg)
            begin
                pc_reg <= ex.res.next_pc;
            end
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            instr_reg <= req.instr;
        end
        if (e_valid_reg && ex.is_load)
        begin
            m_res_reg <= ex.res;
        end
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_res;
        end
    end

    assign head             = fifo_reg[rd_ptr_reg];
    assign rsp.valid        = (cnt_reg != 2'd0);
    assign rsp.next_pc      = head.next_pc;
    assign rsp.branch_taken = head.branch_taken;
    assign rsp.reg_write    = head.reg_write;
    assign rsp.write_reg    = head.write_reg;
    assign rsp.write_value  = head.write_value;
    assign rsp.mem_write    = head.mem_write;
    assign rsp.mem_index    = head.mem_index;
    assign rsp.unknown_op   = head.unknown_op;

`ifndef NO_ASSERTIONS
    a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(e_valid_reg && m_valid_reg))
        else $error("execute and load stages both occupied");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue overflow");

    a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> e_valid_reg)
        else $error("accepted instruction did not reach execute");

    a_load_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && ex.is_load) |=> m_valid_reg)
        else $error("load did not enter memory stage");

    a_no_r0: assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr.en |-> (rf_wr.addr != '0))
        else $error("write to r0");
`endif

endmodule
